@@ hw/rtl/pcsr_pkg.sv @@
package pcsr_pkg;

  localparam int unsigned ScaleFracBits = 8;
  localparam int unsigned MaxResults    = 4;

  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhHwLo      = 4'd1,
    PhHwHi      = 4'd2,
    PhTextWord  = 4'd3,
    PhTextStr   = 4'd4,
    PhCopy3     = 4'd5,
    PhRasHdrLo  = 4'd6,
    PhRasHdrHi  = 4'd7,
    PhRasData   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KCopy  = 3'd0,
    KX     = 3'd1,
    KY     = 3'd2,
    KR     = 3'd3,
    KFat   = 3'd4,
    KCount = 3'd5
  } kind_e;

  localparam logic [2:0] RegXOffset = 3'd0;
  localparam logic [2:0] RegYOffset = 3'd1;
  localparam logic [2:0] RegXScale  = 3'd2;
  localparam logic [2:0] RegYScale  = 3'd3;
  localparam logic [2:0] RegFatten  = 3'd4;

  localparam logic [7:0] OpM  = 8'h6d;
  localparam logic [7:0] OpD  = 8'h64;
  localparam logic [7:0] OpC  = 8'h63;
  localparam logic [7:0] OpF  = 8'h66;
  localparam logic [7:0] OpO  = 8'h6f;
  localparam logic [7:0] OpW  = 8'h77;
  localparam logic [7:0] OpA  = 8'h61;
  localparam logic [7:0] OpAU = 8'h41;
  localparam logic [7:0] OpT  = 8'h74;
  localparam logic [7:0] OpCU = 8'h43;
  localparam logic [7:0] OpP  = 8'h70;
  localparam logic [7:0] OpN  = 8'h6e;
  localparam logic [7:0] OpX  = 8'h78;
  localparam logic [7:0] OpR  = 8'h72;
  // dropped commands
  localparam logic [7:0] OpE  = 8'h65;
  localparam logic [7:0] OpB  = 8'h62;

  // result run handed from parser to output buffer
  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] bytes;
  } run_t;

endpackage

@@ hw/rtl/pcsr_scale.sv @@
module pcsr_scale #(
  parameter int unsigned FracBits = pcsr_pkg::ScaleFracBits
) (
  input  logic signed [15:0] value_i,
  input  logic signed [15:0] offset_i,
  input  logic [16:0]        scale_i,
  input  logic               radius_i,
  output logic [15:0]        result_o
);
  logic signed [16:0] sum;
  logic [16:0]        mag_in;
  logic [33:0]        prod;
  logic [33:0]        mag;
  logic               neg;

  always_comb begin
    sum    = radius_i ? 17'(value_i) : 17'(value_i) + 17'(offset_i);
    neg    = sum[16];
    mag_in = neg ? 17'(-sum) : 17'(sum);
    prod   = 34'(mag_in) * 34'(scale_i);
    mag    = radius_i ? (prod >> (FracBits + 1)) : (prod >> FracBits);
    if (mag == '0) begin
      result_o = '0;
    end else if (!neg && mag > 34'd32767) begin
      result_o = 16'h7fff;
    end else if (neg && mag > 34'd32768) begin
      result_o = 16'h8000;
    end else if (neg) begin
      result_o = 16'(-mag);
    end else begin
      result_o = mag[15:0];
    end
  end
endmodule

@@ hw/rtl/plot_command_stream_rescaler.sv @@
// Channel   | Dir | Content
// s_axis    | in  | tdata[7:0] in_byte
// m_axis    | out | tdata[7:0] out_byte, tlast last_of_run
// apb       | in  | x_offset, y_offset, x_scale, y_scale, fatten at 0,4,8,12,16
// One input byte per cycle while the output buffer is empty or sends its last byte; its
// result run of up to four bytes leaves one byte per cycle from the output buffer while
// m_axis_tready is high. The input is held while a run drains. Bytes that give no result
// do not hold the input. Output stalls hold the input. Reset rst_ni is asynchronous.
// It clears parse state, offsets, fatten and buffer; scales reset to 1 << ScaleFracBits.
module plot_command_stream_rescaler #(
  parameter int unsigned ScaleFracBits = pcsr_pkg::ScaleFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] x_off_q, y_off_q, x_sc_q, y_sc_q, fat_q;

  pcsr_pkg::phase_e ph_q, ph_d;
  logic [7:0]  op_q, op_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  lo_q, lo_d;
  logic [23:0] tw_q, tw_d;
  logic [15:0] pairs_q, pairs_d;
  logic [7:0]  ras_q, ras_d;
  logic        par_q, par_d;

  logic [31:0] buf_q;
  logic [2:0]  left_q;
  pcsr_pkg::run_t run;

  logic        take;
  logic [7:0]  b;
  logic [15:0] hw;
  pcsr_pkg::kind_e kind;
  logic        arc;
  logic [15:0] sc_res, hw_out;
  logic signed [15:0] sc_off;
  logic [16:0] sc_scale, ssum;
  logic [26:0] tprod;
  logic [26:0] tsz;
  logic [4:0]  tfin;
  logic        done;
  logic [15:0] pairs_m1;

  assign pready = 1'b1;
  assign s_axis_tready = (left_q == '0) || ((left_q == 3'd1) && m_axis_tready);
  assign take = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;
  assign hw = {b, lo_q};
  assign arc = (op_q == pcsr_pkg::OpA) || (op_q == pcsr_pkg::OpAU);
  assign ssum = 17'(x_sc_q) + 17'(y_sc_q);

  always_comb begin
    case (op_q)
      pcsr_pkg::OpC: kind = (idx_q == 3'd0) ? pcsr_pkg::KCopy :
                            (idx_q == 3'd1) ? pcsr_pkg::KX :
                            (idx_q == 3'd2) ? pcsr_pkg::KY : pcsr_pkg::KR;
      pcsr_pkg::OpF: kind = pcsr_pkg::KFat;
      pcsr_pkg::OpO: kind = pcsr_pkg::KCopy;
      pcsr_pkg::OpA, pcsr_pkg::OpAU: begin
        if (idx_q == 3'd0) kind = pcsr_pkg::KCopy;
        else if (idx_q == 3'd1) kind = pcsr_pkg::KCount;
        else kind = idx_q[0] ? pcsr_pkg::KY : pcsr_pkg::KX;
      end
      default: kind = idx_q[0] ? pcsr_pkg::KY : pcsr_pkg::KX;
    endcase
  end

  always_comb begin
    case (kind)
      pcsr_pkg::KX: begin
        sc_off = x_off_q; sc_scale = 17'(x_sc_q);
      end
      pcsr_pkg::KY: begin
        sc_off = y_off_q; sc_scale = 17'(y_sc_q);
      end
      default: begin
        sc_off = '0; sc_scale = ssum;
      end
    endcase
  end

  pcsr_scale #(.FracBits(ScaleFracBits)) u_scale (
    .value_i  (hw),
    .offset_i (sc_off),
    .scale_i  (sc_scale),
    .radius_i (kind == pcsr_pkg::KR),
    .result_o (sc_res)
  );

  always_comb begin
    case (kind)
      pcsr_pkg::KX, pcsr_pkg::KY, pcsr_pkg::KR: hw_out = sc_res;
      pcsr_pkg::KFat: hw_out = hw + fat_q;
      default: hw_out = hw;
    endcase
  end

  always_comb begin
    tprod = 27'(tw_q[4:0]) * 27'(ssum) + (27'd1 << ScaleFracBits);
    tsz   = tprod >> (ScaleFracBits + 1);
    if (tsz == '0) tfin = 5'd1;
    else if (tsz > 27'd31) tfin = 5'd31;
    else tfin = tsz[4:0];
  end

  assign pairs_m1 = pairs_q - 16'd1;

  always_comb begin
    ph_d = ph_q; op_d = op_q; idx_d = idx_q; lo_d = lo_q; tw_d = tw_q;
    pairs_d = pairs_q; ras_d = ras_q; par_d = par_q;
    run.cnt = '0; run.bytes = '0;
    done = 1'b0;
    case (ph_q)
      pcsr_pkg::PhIdle: begin
        op_d = b; idx_d = '0;
        case (b)
          pcsr_pkg::OpM, pcsr_pkg::OpD, pcsr_pkg::OpC, pcsr_pkg::OpF,
          pcsr_pkg::OpO, pcsr_pkg::OpW, pcsr_pkg::OpA, pcsr_pkg::OpAU: begin
            run.cnt = 3'd1; run.bytes[7:0] = b; ph_d = pcsr_pkg::PhHwLo;
          end
          pcsr_pkg::OpT: begin
            run.cnt = 3'd1; run.bytes[7:0] = b; tw_d = '0;
            ph_d = pcsr_pkg::PhTextWord;
          end
          pcsr_pkg::OpCU: begin
            run.cnt = 3'd1; run.bytes[7:0] = b; ph_d = pcsr_pkg::PhCopy3;
          end
          pcsr_pkg::OpP, pcsr_pkg::OpN, pcsr_pkg::OpX: begin
            run.cnt = 3'd1; run.bytes[7:0] = b;
          end
          pcsr_pkg::OpR: begin
            if (!par_q) begin
              run.cnt = 3'd2; run.bytes[15:0] = {pcsr_pkg::OpR, pcsr_pkg::OpN};
            end else begin
              run.cnt = 3'd1; run.bytes[7:0] = pcsr_pkg::OpR;
            end
            ph_d = pcsr_pkg::PhRasHdrLo;
          end
          default: ;
        endcase
      end
      pcsr_pkg::PhHwLo: begin
        lo_d = b; ph_d = pcsr_pkg::PhHwHi;
      end
      pcsr_pkg::PhHwHi: begin
        run.cnt = 3'd2; run.bytes[15:0] = hw_out;
        idx_d = idx_q + 3'd1;
        if (arc) begin
          if (kind == pcsr_pkg::KCount) begin
            if (hw[15]) done = 1'b1;
            else pairs_d = hw + 16'd1;
          end else if (kind == pcsr_pkg::KY) begin
            pairs_d = pairs_m1;
            if (pairs_m1 == '0) done = 1'b1;
            else idx_d = 3'd2;
          end
        end else begin
          case (op_q)
            pcsr_pkg::OpM, pcsr_pkg::OpD: done = (idx_d >= 3'd2);
            pcsr_pkg::OpC, pcsr_pkg::OpW: done = (idx_d >= 3'd4);
            default: done = (idx_d >= 3'd1);
          endcase
        end
        ph_d = done ? pcsr_pkg::PhIdle : pcsr_pkg::PhHwLo;
      end
      pcsr_pkg::PhTextWord: begin
        if (idx_q < 3'd3) begin
          case (idx_q[1:0])
            2'd0: tw_d[7:0] = tw_q[7:0] | b;
            2'd1: tw_d[15:8] = tw_q[15:8] | b;
            default: tw_d[23:16] = tw_q[23:16] | b;
          endcase
          idx_d = idx_q + 3'd1;
        end else begin
          run.cnt = 3'd4;
          run.bytes = {b, tw_q[23:8], tw_q[7:5], tfin};
          ph_d = pcsr_pkg::PhTextStr;
        end
      end
      pcsr_pkg::PhTextStr: begin
        run.cnt = 3'd1; run.bytes[7:0] = b;
        if (b == 8'd0) ph_d = pcsr_pkg::PhIdle;
      end
      pcsr_pkg::PhCopy3: begin
        run.cnt = 3'd1; run.bytes[7:0] = b;
        idx_d = idx_q + 3'd1;
        if (idx_d >= 3'd3) ph_d = pcsr_pkg::PhIdle;
      end
      pcsr_pkg::PhRasHdrLo: begin
        lo_d = b; ph_d = pcsr_pkg::PhRasHdrHi;
      end
      pcsr_pkg::PhRasHdrHi: begin
        run.cnt = 3'd2; run.bytes[15:0] = hw;
        if (lo_q == 8'hff && b == 8'hff) begin
          ph_d = pcsr_pkg::PhIdle;
        end else begin
          ras_d = lo_q; idx_d = '0;
          ph_d = (lo_q != '0) ? pcsr_pkg::PhRasData : pcsr_pkg::PhRasHdrLo;
        end
      end
      pcsr_pkg::PhRasData: begin
        run.cnt = 3'd1; run.bytes[7:0] = b;
        if (idx_q[0]) begin
          ras_d = ras_q - 8'd1;
          if (ras_q == 8'd1) ph_d = pcsr_pkg::PhRasHdrLo;
        end
        idx_d = {2'b00, ~idx_q[0]};
      end
      default: ph_d = pcsr_pkg::PhIdle;
    endcase
    par_d = par_q ^ run.cnt[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= pcsr_pkg::PhIdle; op_q <= '0; idx_q <= '0; lo_q <= '0; tw_q <= '0;
      pairs_q <= '0; ras_q <= '0; par_q <= 1'b0;
    end else if (take) begin
      ph_q <= ph_d; op_q <= op_d; idx_q <= idx_d; lo_q <= lo_d; tw_q <= tw_d;
      pairs_q <= pairs_d; ras_q <= ras_d; par_q <= par_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      buf_q  <= '0;
    end else if (take) begin
      left_q <= run.cnt;
      buf_q  <= run.bytes;
    end else if (m_axis_tvalid && m_axis_tready) begin
      left_q <= left_q - 3'd1;
      buf_q  <= {8'd0, buf_q[31:8]};
    end
  end

  assign m_axis_tvalid = (left_q != '0);
  assign m_axis_tdata  = buf_q[7:0];
  assign m_axis_tlast  = (left_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= '0; y_off_q <= '0; fat_q <= '0;
      x_sc_q <= 16'(1 << ScaleFracBits); y_sc_q <= 16'(1 << ScaleFracBits);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        pcsr_pkg::RegXOffset: x_off_q <= pwdata[15:0];
        pcsr_pkg::RegYOffset: y_off_q <= pwdata[15:0];
        pcsr_pkg::RegXScale:  x_sc_q  <= pwdata[15:0];
        pcsr_pkg::RegYScale:  y_sc_q  <= pwdata[15:0];
        pcsr_pkg::RegFatten:  fat_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pcsr_pkg::RegXOffset: prdata = {16'd0, x_off_q};
      pcsr_pkg::RegYOffset: prdata = {16'd0, y_off_q};
      pcsr_pkg::RegXScale:  prdata = {16'd0, x_sc_q};
      pcsr_pkg::RegYScale:  prdata = {16'd0, y_sc_q};
      pcsr_pkg::RegFatten:  prdata = {16'd0, fat_q};
      default: prdata = '0;
    endcase
  end
endmodule
